// ===== design/sbmc_pkg.sv =====
package sbmc_pkg;

	localparam int PULSE_BITS_DEF  = 24;
	localparam int PERIOD_BITS_DEF = 16;

	localparam int ACT_W      = 3;
	localparam int CLK_W      = 27;
	localparam int HZ_W       = 20;
	localparam int SPM_W      = 16;
	localparam int DIST_W     = 16;
	localparam int CFG_W      = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int PROD_W     = DIST_W + SPM_W;
	localparam int MUL_SHIFT  = 12;
	localparam int STEPS_W    = PROD_W - MUL_SHIFT;
	localparam int DIV_CNT_W  = $clog2(CLK_W);

	localparam logic [CLK_W-1:0] TCLK_RST = CLK_W'(84000000);
	localparam logic [HZ_W-1:0]  HZ_RST   = HZ_W'(4500);
	localparam logic [SPM_W-1:0] SPM_RST  = SPM_W'(20480);

	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_HZ       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = CFG_IDX_W'(2);

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK  = 3'd0,
		ACT_POLL  = 3'd1,
		ACT_SEND  = 3'd2,
		ACT_MOVE  = 3'd3,
		ACT_RESET = 3'd4,
		ACT_STOP  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic apply_now;
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic needs_start;
		logic out_free;
		logic div_done;
	} sts_t;

endpackage

// ===== design/sbmc_if.sv =====
interface sbmc_item_if #(
	parameter int PULSE_BITS = sbmc_pkg::PULSE_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [sbmc_pkg::ACT_W-1:0]     action;
	logic                           ir_detected;
	logic [PULSE_BITS-1:0]          pulse_count;
	logic [sbmc_pkg::DIST_W-1:0]    distance_mm;

	modport source (output valid, action, ir_detected, pulse_count, distance_mm, input ready);
	modport sink (input valid, action, ir_detected, pulse_count, distance_mm, output ready);
endinterface

interface sbmc_result_if #(
	parameter int PULSE_BITS = sbmc_pkg::PULSE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  step_out;
	logic                  enable_out;
	logic                  belt_stopped;
	logic                  move_done;
	logic [PULSE_BITS-1:0] pulses_left;

	modport source (output valid, step_out, enable_out, belt_stopped, move_done, pulses_left,
		input ready);
	modport sink (input valid, step_out, enable_out, belt_stopped, move_done, pulses_left,
		output ready);
endinterface

// ===== design/stepper_belt_move_controller_core.sv =====
// Ticks, polls that need no timer start, resets, stops and ignored commands apply at once:
// the result beat is registered and valid the cycle after acceptance, one item per cycle
// while the output register is free. A start (first poll in run mode, non-zero send or move)
// runs the bit-serial period divider, one quotient bit per cycle; no item enters till commit.
// Reset is asynchronous and active low: run mode, timer and driver off, no move, period zero,
// configuration back to its default values; the block accepts items straight after.
module stepper_belt_move_controller_core #(
	parameter int PULSE_BITS  = sbmc_pkg::PULSE_BITS_DEF,
	parameter int PERIOD_BITS = sbmc_pkg::PERIOD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sbmc_item_if.sink                      item,
	sbmc_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [sbmc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sbmc_pkg::CFG_W-1:0]     cfg_data
);
	sbmc_pkg::cmd_t cmd;
	sbmc_pkg::sts_t sts;

	sbmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sbmc_dp #(
		.PULSE_BITS  (PULSE_BITS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

`ifndef SYNTH
	a_apply_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_now |=> result.valid)
		else $error("immediate item produced no result beat");

	a_commit_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result.valid)
		else $error("started move produced no result beat");

	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !item.ready)
		else $error("new item taken while the divider is busy");

	a_ready_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!result.valid || result.ready))
		else $error("item taken while the output register is full");
`endif
endmodule

// ===== design/sbmc_div.sv =====
module sbmc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sbmc_pkg::CLK_W-1:0]   dividend,
	input  logic [sbmc_pkg::HZ_W-1:0]    divisor,
	output logic [sbmc_pkg::CLK_W-1:0]   quotient,
	output logic                         done
);
	localparam int NW = sbmc_pkg::CLK_W;
	localparam int DW = sbmc_pkg::HZ_W;
	localparam int CW = sbmc_pkg::DIV_CNT_W;

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          borrow;

	assign rem_sh   = {rem_q, quo_q[NW-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign borrow   = diff[DW+1];
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ~borrow};
			if (!borrow) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= rem_sh[DW-1:0];
			end
		end
	end
endmodule

// ===== design/sbmc_ctrl.sv =====
module sbmc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  sbmc_pkg::sts_t sts,
	output sbmc_pkg::cmd_t cmd
);
	sbmc_pkg::state_t state_q;
	sbmc_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			sbmc_pkg::ST_IDLE: begin
				cmd.in_ready = sts.out_free;
				if (sts.in_valid && sts.out_free) begin
					if (sts.needs_start) begin
						cmd.capture = 1'b1;
						state_n     = sbmc_pkg::ST_DIV;
					end else begin
						cmd.apply_now = 1'b1;
					end
				end
			end
			sbmc_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_n = sbmc_pkg::ST_COMMIT;
				end
			end
			sbmc_pkg::ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = sbmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sbmc_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

// ===== design/sbmc_dp.sv =====
module sbmc_dp #(
	parameter int PULSE_BITS  = sbmc_pkg::PULSE_BITS_DEF,
	parameter int PERIOD_BITS = sbmc_pkg::PERIOD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sbmc_item_if.sink                        item,
	sbmc_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [sbmc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sbmc_pkg::CFG_W-1:0]       cfg_data,
	input  sbmc_pkg::cmd_t                   cmd,
	output sbmc_pkg::sts_t                   sts
);
	localparam int CKW = sbmc_pkg::CLK_W;
	localparam int HZW = sbmc_pkg::HZ_W;
	localparam int PW  = sbmc_pkg::PROD_W;
	localparam int SW  = (sbmc_pkg::STEPS_W > PULSE_BITS) ? sbmc_pkg::STEPS_W : PULSE_BITS;
	localparam int QW  = (PERIOD_BITS > CKW) ? PERIOD_BITS : CKW;

	localparam logic [PULSE_BITS-1:0]  PULSE_MAX  = '1;
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

	logic [CKW-1:0]                 tclk_q;
	logic [HZW-1:0]                 hz_q;
	logic [sbmc_pkg::SPM_W-1:0]     spm_q;

	logic                   stopped_q, stopped_n;
	logic                   run_q, run_n;
	logic                   move_q, move_n;
	logic [PULSE_BITS-1:0]  rem_q, rem_n;
	logic                   timer_q, timer_n;
	logic                   drv_q, drv_n;
	logic [PERIOD_BITS-1:0] count_q, count_n;
	logic [PERIOD_BITS-1:0] reload_q, reload_n;

	logic                   st_poll_q;
	logic                   st_move_q;
	logic [PULSE_BITS-1:0]  pulses_q;
	logic [PW-1:0]          prod_q;

	logic                   ovalid_q;
	logic                   step_q;
	logic                   en_q;
	logic                   bstop_q;
	logic                   mdone_q;
	logic [PULSE_BITS-1:0]  left_q;

	logic [HZW-1:0]                 hz_eff;
	logic [CKW-1:0]                 quo;
	logic                           div_done;
	logic [QW-1:0]                  quo_m1;
	logic [PERIOD_BITS-1:0]         period;
	logic [sbmc_pkg::STEPS_W-1:0]   steps_raw;
	logic [SW-1:0]                  steps_ext;
	logic [PULSE_BITS-1:0]          move_pulses;
	logic                           needs_start;
	logic                           out_free;
	logic                           load;

	assign hz_eff = (hz_q == '0) ? HZW'(1) : hz_q;

	sbmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.capture),
		.dividend (tclk_q),
		.divisor  (hz_eff),
		.quotient (quo),
		.done     (div_done)
	);

	assign quo_m1 = QW'(quo) - QW'(1);
	assign period = (quo == '0 || quo_m1 > QW'(PERIOD_MAX)) ? PERIOD_MAX
		: PERIOD_BITS'(quo_m1);

	assign steps_raw   = prod_q[PW-1:sbmc_pkg::MUL_SHIFT];
	assign steps_ext   = SW'(steps_raw);
	assign move_pulses = (steps_ext > SW'(PULSE_MAX)) ? PULSE_MAX : PULSE_BITS'(steps_ext);

	always_comb begin
		needs_start = 1'b0;
		unique case (item.action)
			sbmc_pkg::ACT_POLL: needs_start = !stopped_q && !run_q && !item.ir_detected;
			sbmc_pkg::ACT_SEND: needs_start = (item.pulse_count != '0);
			sbmc_pkg::ACT_MOVE: needs_start = (item.distance_mm != '0);
			default:            needs_start = 1'b0;
		endcase
	end

	assign out_free = !ovalid_q || result.ready;
	assign load     = cmd.apply_now || cmd.commit;

	assign sts.in_valid    = item.valid;
	assign sts.needs_start = needs_start;
	assign sts.out_free    = out_free;
	assign sts.div_done    = div_done;

	assign item.ready = cmd.in_ready;

	always_comb begin
		stopped_n = stopped_q;
		run_n     = run_q;
		move_n    = move_q;
		rem_n     = rem_q;
		timer_n   = timer_q;
		drv_n     = drv_q;
		count_n   = count_q;
		reload_n  = reload_q;
		if (cmd.commit) begin
			drv_n    = 1'b1;
			timer_n  = 1'b1;
			count_n  = '0;
			reload_n = period;
			if (st_poll_q) begin
				run_n = 1'b1;
			end else begin
				move_n = 1'b1;
				rem_n  = st_move_q ? move_pulses : pulses_q;
			end
		end else begin
			case (item.action) inside
				sbmc_pkg::ACT_TICK: begin
					if (timer_q) begin
						if (count_q >= reload_q) begin
							count_n = '0;
							if (move_q && rem_q != '0) begin
								rem_n = rem_q - PULSE_BITS'(1);
								if (rem_q == PULSE_BITS'(1)) begin
									timer_n = 1'b0;
									drv_n   = 1'b0;
									move_n  = 1'b0;
								end
							end
						end else begin
							count_n = count_q + PERIOD_BITS'(1);
						end
					end
				end
				sbmc_pkg::ACT_POLL: begin
					if (!stopped_q && item.ir_detected) begin
						timer_n   = 1'b0;
						drv_n     = 1'b0;
						run_n     = 1'b0;
						stopped_n = 1'b1;
					end
				end
				sbmc_pkg::ACT_RESET, sbmc_pkg::ACT_STOP: begin
					stopped_n = (item.action == sbmc_pkg::ACT_STOP);
					run_n     = 1'b0;
					timer_n   = 1'b0;
					drv_n     = 1'b0;
					move_n    = 1'b0;
					rem_n     = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tclk_q <= sbmc_pkg::TCLK_RST;
			hz_q   <= sbmc_pkg::HZ_RST;
			spm_q  <= sbmc_pkg::SPM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sbmc_pkg::CFG_TIMER_CLOCK:  tclk_q <= cfg_data[CKW-1:0];
				sbmc_pkg::CFG_RUN_HZ:       hz_q   <= cfg_data[HZW-1:0];
				sbmc_pkg::CFG_STEPS_PER_MM: spm_q  <= cfg_data[sbmc_pkg::SPM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			run_q     <= 1'b0;
			move_q    <= 1'b0;
			rem_q     <= '0;
			timer_q   <= 1'b0;
			drv_q     <= 1'b0;
			count_q   <= '0;
			reload_q  <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (load) begin
				stopped_q <= stopped_n;
				run_q     <= run_n;
				move_q    <= move_n;
				rem_q     <= rem_n;
				timer_q   <= timer_n;
				drv_q     <= drv_n;
				count_q   <= count_n;
				reload_q  <= reload_n;
				ovalid_q  <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			st_poll_q <= (item.action == sbmc_pkg::ACT_POLL);
			st_move_q <= (item.action == sbmc_pkg::ACT_MOVE);
			pulses_q  <= item.pulse_count;
			prod_q    <= PW'(item.distance_mm) * PW'(spm_q);
		end
		if (load) begin
			step_q  <= timer_n && (count_n < (reload_n >> 1));
			en_q    <= drv_n;
			bstop_q <= stopped_n;
			mdone_q <= !move_n;
			left_q  <= rem_n;
		end
	end

	assign result.valid        = ovalid_q;
	assign result.step_out     = step_q;
	assign result.enable_out   = en_q;
	assign result.belt_stopped = bstop_q;
	assign result.move_done    = mdone_q;
	assign result.pulses_left  = left_q;
endmodule

// ===== bench/belt_status_checker.sv =====
`timescale 1ns / 100ps

module belt_status_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  logic [sbmc_pkg::ACT_W-1:0]     action,
	input  logic                           ir_detected,
	input  logic [23:0]                    pulse_count,
	input  logic [sbmc_pkg::DIST_W-1:0]    distance_mm,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic                           step_out,
	input  logic                           enable_out,
	input  logic                           belt_stopped,
	input  logic                           move_done,
	input  logic [23:0]                    pulses_left,
	input  logic                           cfg_we,
	input  logic [sbmc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sbmc_pkg::CFG_W-1:0]     cfg_data,
	output int                             pending,
	output int                             mismatches
);
	import sbmc_pkg::*;

	localparam int PULSE_W  = PULSE_BITS_DEF;
	localparam int PERIOD_W = PERIOD_BITS_DEF;

	typedef struct packed {
		logic               step_out;
		logic               enable_out;
		logic               belt_stopped;
		logic               move_done;
		logic [PULSE_W-1:0] pulses_left;
	} belt_status_t;

	logic [CLK_W-1:0]    tclk_hz;
	logic [HZ_W-1:0]     rate_hz;
	logic [SPM_W-1:0]    spm;
	logic                stopped_mode;
	logic                run_started;
	logic                move_active;
	logic                timer_on;
	logic                driver_on;
	logic [PULSE_W-1:0]  pulses_rem;
	logic [PERIOD_W-1:0] period_cnt;
	logic [PERIOD_W-1:0] period_top;
	belt_status_t        belt_status_q[$];

	initial begin
		pending = 0;
		mismatches = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// The period is fixed when the timer starts; later register writes do not touch it.
	task automatic start_stepping();
		logic [CLK_W-1:0] quotient;
		quotient = tclk_hz / ((rate_hz == '0) ? CLK_W'(1) : CLK_W'(rate_hz));
		if (quotient == '0 || (quotient - 1'b1) > CLK_W'({PERIOD_W{1'b1}}))
			period_top = '1;
		else
			period_top = PERIOD_W'(quotient - 1'b1);
		period_cnt = '0;
		timer_on = 1'b1;
	endtask

	task automatic begin_move(input logic [PULSE_W-1:0] count);
		driver_on = 1'b1;
		pulses_rem = count;
		move_active = 1'b1;
		start_stepping();
	endtask

	task automatic halt_belt(input logic to_stopped);
		stopped_mode = to_stopped;
		run_started = 1'b0;
		timer_on = 1'b0;
		driver_on = 1'b0;
		move_active = 1'b0;
		pulses_rem = '0;
	endtask

	task automatic advance_belt(input logic [ACT_W-1:0] act, input logic ir,
		input logic [PULSE_W-1:0] pulses, input logic [DIST_W-1:0] span,
		output belt_status_t st);
		logic [PROD_W-1:0] steps;
		case (act)
			ACT_TICK: begin
				if (timer_on) begin
					if (period_cnt >= period_top) begin
						period_cnt = '0;
						if (move_active && pulses_rem != '0) begin
							pulses_rem = pulses_rem - 1'b1;
							if (pulses_rem == '0) begin
								timer_on = 1'b0;
								driver_on = 1'b0;
								move_active = 1'b0;
							end
						end
					end else begin
						period_cnt = period_cnt + 1'b1;
					end
				end
			end
			ACT_POLL: begin
				if (!stopped_mode) begin
					if (!run_started) begin
						driver_on = 1'b1;
						start_stepping();
						run_started = 1'b1;
					end
					if (ir) begin
						timer_on = 1'b0;
						driver_on = 1'b0;
						run_started = 1'b0;
						stopped_mode = 1'b1;
					end
				end
			end
			ACT_SEND: begin
				if (pulses != '0)
					begin_move(pulses);
			end
			ACT_MOVE: begin
				if (span != '0) begin
					steps = (PROD_W'(span) * PROD_W'(spm)) >> MUL_SHIFT;
					if (steps > PROD_W'({PULSE_W{1'b1}}))
						steps = PROD_W'({PULSE_W{1'b1}});
					begin_move(PULSE_W'(steps));
				end
			end
			ACT_RESET: halt_belt(1'b0);
			ACT_STOP:  halt_belt(1'b1);
			default: ;
		endcase
		st.step_out = timer_on && (period_cnt < (period_top >> 1));
		st.enable_out = driver_on;
		st.belt_stopped = stopped_mode;
		st.move_done = !move_active;
		st.pulses_left = pulses_rem;
	endtask

	always @(posedge clk or negedge arst_n) begin
		belt_status_t want;
		belt_status_t got;
		if (!arst_n) begin
			tclk_hz = TCLK_RST;
			rate_hz = HZ_RST;
			spm = SPM_RST;
			halt_belt(1'b0);
			period_cnt = '0;
			period_top = '0;
			belt_status_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				got = {step_out, enable_out, belt_stopped, move_done, pulses_left};
				if (belt_status_q.size() == 0) begin
					report_mismatch("result beat with nothing expected, pulses_left",
						32'(got.pulses_left), 32'd0);
				end else begin
					want = belt_status_q.pop_front();
					if (got.step_out !== want.step_out)
						report_mismatch("step_out", 32'(got.step_out), 32'(want.step_out));
					if (got.enable_out !== want.enable_out)
						report_mismatch("enable_out", 32'(got.enable_out),
							32'(want.enable_out));
					if (got.belt_stopped !== want.belt_stopped)
						report_mismatch("belt_stopped", 32'(got.belt_stopped),
							32'(want.belt_stopped));
					if (got.move_done !== want.move_done)
						report_mismatch("move_done", 32'(got.move_done), 32'(want.move_done));
					if (got.pulses_left !== want.pulses_left)
						report_mismatch("pulses_left", 32'(got.pulses_left),
							32'(want.pulses_left));
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TIMER_CLOCK:  tclk_hz = cfg_data[CLK_W-1:0];
					CFG_RUN_HZ:       rate_hz = cfg_data[HZ_W-1:0];
					CFG_STEPS_PER_MM: spm = cfg_data[SPM_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				advance_belt(action, ir_detected, pulse_count, distance_mm, want);
				belt_status_q.push_back(want);
			end
		end
		pending <= belt_status_q.size();
	end

endmodule

// ===== bench/stepper_belt_move_controller_core_tb.sv =====
`timescale 1ns / 100ps

module stepper_belt_move_controller_core_tb;
	import sbmc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_BEATS  = 100;

	localparam logic [ACT_W-1:0]     ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0]     ACT_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	int                   pending;
	int                   mismatches;
	int                   cycle_count = 0;
	int                   burst_left = 0;
	bit                   hold_req = 1'b0;
	bit                   steady_feed = 1'b0;
	int                   phase_idx;
	int                   beat_idx;
	logic [CLK_W-1:0]     phase_tclk;
	logic [HZ_W-1:0]      phase_hz;
	logic [SPM_W-1:0]     phase_spm;

	sbmc_item_if   item_ch ();
	sbmc_result_if result_ch ();

	stepper_belt_move_controller_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	belt_status_checker status_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.action       (item_ch.action),
		.ir_detected  (item_ch.ir_detected),
		.pulse_count  (item_ch.pulse_count),
		.distance_mm  (item_ch.distance_mm),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.step_out     (result_ch.step_out),
		.enable_out   (result_ch.enable_out),
		.belt_stopped (result_ch.belt_stopped),
		.move_done    (result_ch.move_done),
		.pulses_left  (result_ch.pulses_left),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// The receiver switches at random between stall patterns; a long hold-off
	// requested by the stimulus is counted out here.
	initial begin
		int hold_left;
		int mode_left;
		int mode;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0:       result_ch.ready <= 1'b1;
					1:       result_ch.ready <= ($urandom_range(0, 1) != 0);
					default: result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic push_beat(input logic [ACT_W-1:0] act, input logic ir,
		input logic [23:0] pulses, input logic [DIST_W-1:0] span);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_feed ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.ir_detected <= ir;
		item_ch.pulse_count <= pulses;
		item_ch.distance_mm <= span;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic random_beat();
		int pick;
		logic [ACT_W-1:0]  act;
		logic              ir;
		logic [23:0]       pulses;
		logic [DIST_W-1:0] span;
		pick = $urandom_range(0, 99);
		ir = 1'($urandom_range(0, 1));
		pulses = 24'($urandom);
		span = DIST_W'($urandom);
		if (pick < 55) begin
			act = ACT_TICK;
		end else if (pick < 65) begin
			act = ACT_POLL;
			ir = ($urandom_range(0, 4) == 0);
		end else if (pick < 75) begin
			act = ACT_SEND;
			if ($urandom_range(0, 7) != 0)
				pulses = 24'($urandom_range(0, 12));
		end else if (pick < 84) begin
			act = ACT_MOVE;
			if ($urandom_range(0, 7) != 0)
				span = DIST_W'($urandom_range(0, 160));
		end else if (pick < 90) begin
			act = ACT_RESET;
		end else if (pick < 96) begin
			act = ACT_STOP;
		end else begin
			act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
		end
		push_beat(act, ir, pulses, span);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_belt(input logic [CLK_W-1:0] tclk, input logic [HZ_W-1:0] hz,
		input logic [SPM_W-1:0] spm, input bit touch_spare);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_TIMER_CLOCK;
		cfg_data <= CFG_W'(tclk);
		@(posedge clk);
		cfg_idx <= CFG_RUN_HZ;
		cfg_data <= CFG_W'(hz);
		@(posedge clk);
		cfg_idx <= CFG_STEPS_PER_MM;
		cfg_data <= CFG_W'(spm);
		@(posedge clk);
		if (touch_spare) begin
			cfg_idx <= CFG_SPARE;
			cfg_data <= CFG_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_TIMER_CLOCK;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_TICK;
		item_ch.ir_detected <= 1'b0;
		item_ch.pulse_count <= '0;
		item_ch.distance_mm <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_SPARE_LO, 1'b1, '1, '1);
		push_beat(ACT_SPARE_HI, 1'b1, '1, '1);
		push_beat(ACT_POLL, 1'b0, '0, '0);
		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_POLL, 1'b1, '0, '0);
		push_beat(ACT_POLL, 1'b0, '0, '0);
		push_beat(ACT_RESET, 1'b0, '0, '0);
		push_beat(ACT_SEND, 1'b0, '0, '1);
		push_beat(ACT_MOVE, 1'b0, '1, '0);
		push_beat(ACT_SEND, 1'b0, '1, '0);
		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_STOP, 1'b0, '0, '0);
		push_beat(ACT_RESET, 1'b0, '0, '0);
		push_beat(ACT_MOVE, 1'b0, '0, '1);
		push_beat(ACT_TICK, 1'b0, '0, '0);
		drain();

		// A one-count period with no steps per millimetre.
		program_belt(CLK_W'(1), '0, '0, 1'b1);
		push_beat(ACT_SEND, 1'b0, 24'd3, '0);
		repeat (4) push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_MOVE, 1'b0, '0, DIST_W'(5));
		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_RESET, 1'b0, '0, '0);
		drain();

		// The timer clock below the step rate saturates the period.
		program_belt(CLK_W'(3), HZ_W'(1000000), '1, 1'b0);
		push_beat(ACT_SEND, 1'b0, 24'd1, '0);
		push_beat(ACT_TICK, 1'b0, '0, '0);
		push_beat(ACT_POLL, 1'b1, '0, '0);

		for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
			drain();
			phase_tclk = CLK_W'($urandom_range(1, 48));
			phase_hz = HZ_W'($urandom_range(0, 6));
			phase_spm = SPM_W'($urandom_range(1, 2048));
			case (phase_idx)
				0: phase_spm = '0;
				1: phase_spm = '1;
				4: begin
					phase_tclk = '1;
					phase_hz = '0;
				end
				5: begin
					phase_tclk = '1;
					phase_hz = HZ_W'(1000000);
				end
				default: ;
			endcase
			program_belt(phase_tclk, phase_hz, phase_spm, 1'b0);
			steady_feed = (phase_idx == 2);
			for (beat_idx = 0; beat_idx < PHASE_BEATS; beat_idx++) begin
				if (phase_idx == 3 && beat_idx == 20)
					hold_req = 1'b1;
				random_beat();
			end
		end

		drain();
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
